// ===== rtl/core/ttm_pkg.sv =====
// Shared constants, types and control structs of the thruster tracking monitor.
`timescale 1ns / 1ps

package ttm_pkg;

    localparam int NUM_THR = 8;
    localparam int THR_W   = 3;
    localparam int DEPTH   = 64;
    localparam int IDX_W   = 6;
    localparam int FILL_W  = 7;
    localparam int TIME_W  = 48;
    localparam int SPD_W   = 16;
    localparam int ENT_W   = SPD_W + TIME_W;
    localparam int ADDR_W  = THR_W + IDX_W;
    localparam int SUM_W   = 23;
    localparam int DIV_W   = 32;
    localparam int DVS_W   = 16;
    localparam int CNT_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_FILTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_TMO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMP_THR   = 3'd5;

    typedef enum logic [1:0] {
        RD_NEWEST,
        RD_OLDEST,
        RD_SUM
    } rd_sel_t;

    typedef enum logic [1:0] {
        DIV_CMD,
        DIV_STS,
        DIV_ERR
    } div_sel_t;

    typedef struct packed {
        logic     latch;
        logic     store_cmd;
        logic     push;
        logic     take_cur;
        logic     set_ns_first;
        logic     evict;
        logic     sum_clr;
        logic     sum_acc;
        logic     div_start;
        logic     div_take;
        logic     classify;
        logic     finish;
        div_sel_t div_sel;
        rd_sel_t  rd_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic th_ok;
        logic new_status;
        logic stime_zero;
        logic any_empty;
        logic ns_zero;
        logic evict_more;
        logic below_thr;
        logic sum_last;
        logic div_done;
        logic need_div;
        logic out_full;
    } dp_sts_t;

endpackage

// ===== rtl/core/ttm_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ttm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ttm_pkg::DIV_W-1:0]  dividend,
    input  logic [ttm_pkg::DVS_W-1:0]  divisor,
    output logic                       busy,
    output logic                       done,
    output logic [ttm_pkg::DIV_W-1:0]  quotient
);
    import ttm_pkg::*;

    logic [DVS_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             qbit;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], qbit};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/ttm_dp.sv =====
// Datapath: sample rings, per-thruster state, sums, divider and result register.
`timescale 1ns / 1ps

module ttm_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ttm_pkg::THR_W-1:0]      thruster,
    input  logic                           new_status,
    input  logic signed [ttm_pkg::SPD_W-1:0] status_speed,
    input  logic [ttm_pkg::TIME_W-1:0]     status_time_us,
    input  logic                           new_command,
    input  logic signed [ttm_pkg::SPD_W-1:0] command_speed,
    input  logic [ttm_pkg::TIME_W-1:0]     command_time_us,
    input  logic                           cfg_valid,
    input  logic [ttm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttm_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [ttm_pkg::THR_W-1:0]      thruster_out,
    output logic                           error_valid,
    output logic [31:0]                    tracking_error,
    output logic signed [ttm_pkg::SPD_W-1:0] command_average,
    output logic signed [ttm_pkg::SPD_W-1:0] status_average,
    output logic [ttm_pkg::FILL_W-1:0]     command_count,
    output logic [ttm_pkg::FILL_W-1:0]     status_count,
    output logic [ttm_pkg::TIME_W-1:0]     elapsed_us,
    output logic [ttm_pkg::TIME_W-1:0]     current_time_us,
    output logic                           underperforming,
    input  ttm_pkg::dp_cmd_t               cmd,
    output ttm_pkg::dp_sts_t               sts
);
    import ttm_pkg::*;

    // configuration
    logic [14:0] dz_reg;
    logic [16:0] tol_reg;
    logic [31:0] win_reg;
    logic [31:0] filt_reg;
    logic [31:0] tmo_reg;
    logic [6:0]  thr_reg;

    // latched item
    logic [THR_W-1:0]  th_reg;
    logic              ns_reg;
    logic [SPD_W-1:0]  ss_reg;
    logic [TIME_W-1:0] st_reg;
    logic              nc_reg;
    logic [SPD_W-1:0]  cs_reg;
    logic [TIME_W-1:0] ct_reg;

    // per-thruster state
    logic [IDX_W-1:0]  chead_reg [NUM_THR];
    logic [FILL_W-1:0] cfill_reg [NUM_THR];
    logic [IDX_W-1:0]  shead_reg [NUM_THR];
    logic [FILL_W-1:0] sfill_reg [NUM_THR];
    logic [TIME_W-1:0] nsince_reg [NUM_THR];
    logic [SPD_W-1:0]  lspd_reg [NUM_THR];
    logic [TIME_W-1:0] ltime_reg [NUM_THR];
    logic              pend_reg [NUM_THR];

    // rings
    logic [ENT_W-1:0] cmem [DEPTH*NUM_THR];
    logic [ENT_W-1:0] smem [DEPTH*NUM_THR];
    logic [ENT_W-1:0] cq_reg;
    logic [ENT_W-1:0] sq_reg;

    // working registers
    logic [TIME_W-1:0]       cur_reg;
    logic [TIME_W-1:0]       cmdt_reg;
    logic [FILL_W-1:0]       k_reg;
    logic signed [SUM_W-1:0] csum_reg;
    logic signed [SUM_W-1:0] ssum_reg;
    logic signed [SPD_W-1:0] cavg_reg;
    logic signed [SPD_W-1:0] savg_reg;
    logic [31:0]             err_reg;
    logic                    idle_reg;

    // result register
    logic                    out_valid_reg;
    logic [THR_W-1:0]        o_th_reg;
    logic                    o_ev_reg;
    logic [31:0]             o_err_reg;
    logic [SPD_W-1:0]        o_cavg_reg;
    logic [SPD_W-1:0]        o_savg_reg;
    logic [FILL_W-1:0]       o_cc_reg;
    logic [FILL_W-1:0]       o_sc_reg;
    logic [TIME_W-1:0]       o_el_reg;
    logic [TIME_W-1:0]       o_cur_reg;
    logic                    o_up_reg;

    // combinational
    logic [IDX_W-1:0]  chead, shead, cidx, sidx;
    logic [FILL_W-1:0] cfill, sfill, k_inc;
    logic [TIME_W-1:0] nsince;
    logic [ADDR_W-1:0] c_raddr, s_raddr, c_waddr, s_waddr;
    logic [ENT_W-1:0]  c_wdata, s_wdata;
    logic              stale;
    logic [SPD_W-1:0]  push_spd;
    logic [TIME_W-1:0] push_time;
    logic signed [TIME_W:0] c_age, s_age, win_s;
    logic              c_old, s_old;
    logic [SUM_W-1:0]  cmag, smag;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic              div_busy, div_done;
    logic [DIV_W-1:0]  div_q;
    logic [SPD_W-1:0]  qs;
    logic [SPD_W:0]    ac, as_mag;
    logic signed [SPD_W:0] sdiff;
    logic [SPD_W-1:0]  adiff;
    logic              idle_now;
    logic              normal;
    logic [TIME_W-1:0] elapsed;

    always_comb
    begin
        chead  = chead_reg[th_reg];
        shead  = shead_reg[th_reg];
        cfill  = cfill_reg[th_reg];
        sfill  = sfill_reg[th_reg];
        nsince = nsince_reg[th_reg];
        k_inc  = k_reg + FILL_W'(1);

        case (cmd.rd_sel)
            RD_OLDEST:
            begin
                cidx = chead - cfill[IDX_W-1:0];
                sidx = shead - sfill[IDX_W-1:0];
            end
            RD_SUM:
            begin
                cidx = chead - IDX_W'(1) - k_reg[IDX_W-1:0];
                sidx = shead - IDX_W'(1) - k_reg[IDX_W-1:0];
            end
            default:
            begin
                cidx = chead - IDX_W'(1);
                sidx = shead - IDX_W'(1);
            end
        endcase
        c_raddr = {th_reg, cidx};
        s_raddr = {th_reg, sidx};
        c_waddr = {th_reg, chead};
        s_waddr = {th_reg, shead};

        stale = ({1'b0, ltime_reg[th_reg]} + {{(TIME_W+1-32){1'b0}}, tmo_reg})
                < {1'b0, st_reg};
        if (pend_reg[th_reg])
        begin
            push_spd  = lspd_reg[th_reg];
            push_time = ltime_reg[th_reg];
        end
        else
        begin
            push_spd  = (cfill != '0 && !stale) ? cq_reg[ENT_W-1:TIME_W] : '0;
            push_time = st_reg;
        end
        c_wdata = {push_spd, push_time};
        s_wdata = {ss_reg, st_reg};

        // eviction: signed age of the oldest entry against the window
        win_s = $signed({{(TIME_W+1-32){1'b0}}, win_reg});
        c_age = $signed({1'b0, cur_reg}) - $signed({1'b0, cq_reg[TIME_W-1:0]});
        s_age = $signed({1'b0, cur_reg}) - $signed({1'b0, sq_reg[TIME_W-1:0]});
        c_old = (cfill != '0) && (c_age > win_s);
        s_old = (sfill != '0) && (s_age > win_s);

        cmag = csum_reg[SUM_W-1] ? SUM_W'(-csum_reg) : SUM_W'(csum_reg);
        smag = ssum_reg[SUM_W-1] ? SUM_W'(-ssum_reg) : SUM_W'(ssum_reg);

        ac     = cavg_reg[SPD_W-1] ? (SPD_W+1)'(-{cavg_reg[SPD_W-1], cavg_reg})
                                   : {1'b0, cavg_reg};
        as_mag = savg_reg[SPD_W-1] ? (SPD_W+1)'(-{savg_reg[SPD_W-1], savg_reg})
                                   : {1'b0, savg_reg};
        sdiff  = $signed({cavg_reg[SPD_W-1], cavg_reg})
                 - $signed({savg_reg[SPD_W-1], savg_reg});
        adiff  = sdiff[SPD_W] ? SPD_W'(-sdiff) : sdiff[SPD_W-1:0];
        idle_now = (ac <= {2'b0, dz_reg}) && (as_mag <= {2'b0, dz_reg});

        case (cmd.div_sel)
            DIV_STS:
            begin
                div_dividend = {{(DIV_W-SUM_W){1'b0}}, smag};
                div_divisor  = {{(DVS_W-FILL_W){1'b0}}, sfill};
            end
            DIV_ERR:
            begin
                div_dividend = {adiff, {SPD_W{1'b0}}};
                div_divisor  = ac[DVS_W-1:0];
            end
            default:
            begin
                div_dividend = {{(DIV_W-SUM_W){1'b0}}, cmag};
                div_divisor  = {{(DVS_W-FILL_W){1'b0}}, cfill};
            end
        endcase
        qs = div_q[SPD_W-1:0];

        normal  = idle_reg || (err_reg <= {15'b0, tol_reg});
        elapsed = (!normal && cmdt_reg > nsince) ? cmdt_reg - nsince : '0;
    end

    ttm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // ring memories, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            cmem[c_waddr] <= c_wdata;
            smem[s_waddr] <= s_wdata;
        end
        cq_reg <= cmem[c_raddr];
        sq_reg <= smem[s_raddr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg   <= 15'd256;
            tol_reg  <= 17'd13107;
            win_reg  <= 32'd1000000;
            filt_reg <= 32'd2000000;
            tmo_reg  <= 32'd1000000;
            thr_reg  <= 7'd4;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEAD_ZONE:  dz_reg   <= cfg_data[14:0];
                CFG_TOLERANCE:  tol_reg  <= cfg_data[16:0];
                CFG_WINDOW:     win_reg  <= cfg_data;
                CFG_ERR_FILTER: filt_reg <= cfg_data;
                CFG_CMD_TMO:    tmo_reg  <= cfg_data;
                CFG_SAMP_THR:   thr_reg  <= cfg_data[6:0];
                default:        ;
            endcase
        end
    end

    // item latch and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            th_reg <= thruster;
            ns_reg <= new_status;
            ss_reg <= status_speed;
            st_reg <= status_time_us;
            nc_reg <= new_command;
            cs_reg <= command_speed;
            ct_reg <= command_time_us;
        end
        if (cmd.take_cur)
        begin
            cmdt_reg <= cq_reg[TIME_W-1:0];
            cur_reg  <= (cq_reg[TIME_W-1:0] > sq_reg[TIME_W-1:0])
                        ? cq_reg[TIME_W-1:0] : sq_reg[TIME_W-1:0];
        end
        if (cmd.sum_clr)
        begin
            k_reg    <= '0;
            csum_reg <= '0;
            ssum_reg <= '0;
        end
        else if (cmd.sum_acc)
        begin
            k_reg <= k_inc;
            if (k_reg < cfill)
                csum_reg <= csum_reg + SUM_W'($signed(cq_reg[ENT_W-1:TIME_W]));
            if (k_reg < sfill)
                ssum_reg <= ssum_reg + SUM_W'($signed(sq_reg[ENT_W-1:TIME_W]));
        end
        if (cmd.div_take)
        begin
            case (cmd.div_sel)
                DIV_STS: savg_reg <= ssum_reg[SUM_W-1] ? -$signed(qs) : $signed(qs);
                DIV_ERR: err_reg  <= div_q;
                default: cavg_reg <= csum_reg[SUM_W-1] ? -$signed(qs) : $signed(qs);
            endcase
        end
        if (cmd.classify)
        begin
            idle_reg <= idle_now;
            err_reg  <= (!idle_now && ac == '0) ? '1 : '0;
        end
        if (cmd.finish)
        begin
            o_th_reg   <= th_reg;
            o_ev_reg   <= !idle_reg;
            o_err_reg  <= err_reg;
            o_cavg_reg <= cavg_reg;
            o_savg_reg <= savg_reg;
            o_cc_reg   <= cfill;
            o_sc_reg   <= sfill;
            o_el_reg   <= elapsed;
            o_cur_reg  <= cur_reg;
            o_up_reg   <= !normal && (elapsed > {16'b0, filt_reg});
        end
    end

    // per-thruster state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_THR; i++)
            begin
                chead_reg[i]  <= '0;
                cfill_reg[i]  <= '0;
                shead_reg[i]  <= '0;
                sfill_reg[i]  <= '0;
                nsince_reg[i] <= '0;
                lspd_reg[i]   <= '0;
                ltime_reg[i]  <= '0;
                pend_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            if (cmd.store_cmd && nc_reg && sts.th_ok)
            begin
                lspd_reg[th_reg]  <= cs_reg;
                ltime_reg[th_reg] <= ct_reg;
                pend_reg[th_reg]  <= 1'b1;
            end
            if (cmd.push)
            begin
                chead_reg[th_reg] <= chead + IDX_W'(1);
                shead_reg[th_reg] <= shead + IDX_W'(1);
                if (cfill != FILL_W'(DEPTH))
                    cfill_reg[th_reg] <= cfill + FILL_W'(1);
                if (sfill != FILL_W'(DEPTH))
                    sfill_reg[th_reg] <= sfill + FILL_W'(1);
                pend_reg[th_reg] <= 1'b0;
            end
            if (cmd.evict)
            begin
                if (c_old)
                    cfill_reg[th_reg] <= cfill - FILL_W'(1);
                if (s_old)
                    sfill_reg[th_reg] <= sfill - FILL_W'(1);
            end
            if (cmd.set_ns_first || (cmd.finish && normal))
                nsince_reg[th_reg] <= cur_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        sts.th_ok      = (th_reg < THR_W'(NUM_THR - 1)) || (th_reg == THR_W'(NUM_THR - 1));
        sts.new_status = ns_reg;
        sts.stime_zero = (st_reg == '0);
        sts.any_empty  = (cfill == '0) || (sfill == '0);
        sts.ns_zero    = (nsince == '0);
        sts.evict_more = c_old || s_old;
        sts.below_thr  = (cfill == '0) || (sfill == '0) ||
                         (cfill < thr_reg) || (sfill < thr_reg);
        sts.sum_last   = (k_inc >= cfill) && (k_inc >= sfill);
        sts.div_done   = div_done;
        sts.need_div   = !idle_now && (ac != '0);
        sts.out_full   = out_valid_reg && !out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign thruster_out    = o_th_reg;
    assign error_valid     = o_ev_reg;
    assign tracking_error  = o_err_reg;
    assign command_average = o_cavg_reg;
    assign status_average  = o_savg_reg;
    assign command_count   = o_cc_reg;
    assign status_count    = o_sc_reg;
    assign elapsed_us      = o_el_reg;
    assign current_time_us = o_cur_reg;
    assign underperforming = o_up_reg;

`ifndef SYNTHESIS
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cfill <= FILL_W'(DEPTH)) && (sfill <= FILL_W'(DEPTH)))
        else $error("ring fill beyond depth");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !out_ready))
        else $error("result written over a pending result");
`endif

endmodule

// ===== rtl/core/ttm_ctrl.sv =====
// Controller: sequences one item through push, eviction, sums and divisions.
`timescale 1ns / 1ps

module ttm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ttm_pkg::dp_sts_t sts,
    output ttm_pkg::dp_cmd_t cmd
);
    import ttm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CMD, S_PUSH, S_NEW0, S_NEW1, S_FIRST, S_EV_RD, S_EV_CHK,
        S_THR, S_SUM_RD, S_SUM_ACC, S_DIV_C, S_DIV_CW, S_DIV_S, S_DIV_SW,
        S_CLASS, S_DIV_E, S_DIV_EW, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel  = RD_NEWEST;
        cmd.div_sel = DIV_CMD;
        case (state_reg)
            S_IDLE:
            begin
                cmd.latch = in_valid;
                if (in_valid)
                    state_next = S_CMD;
            end
            S_CMD:
            begin
                cmd.store_cmd = 1'b1;
                if (!sts.th_ok)
                    state_next = S_IDLE;
                else if (!sts.new_status)
                    state_next = S_NEW0;
                else if (sts.stime_zero)
                    state_next = S_IDLE;
                else
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_NEW0;
            end
            S_NEW0:
                state_next = sts.any_empty ? S_IDLE : S_NEW1;
            S_NEW1:
            begin
                cmd.take_cur = 1'b1;
                state_next   = S_FIRST;
            end
            S_FIRST:
            begin
                cmd.set_ns_first = sts.ns_zero;
                state_next = sts.ns_zero ? S_IDLE : S_EV_RD;
            end
            S_EV_RD:
            begin
                cmd.rd_sel = RD_OLDEST;
                state_next = S_EV_CHK;
            end
            S_EV_CHK:
            begin
                cmd.evict  = 1'b1;
                state_next = sts.evict_more ? S_EV_RD : S_THR;
            end
            S_THR:
            begin
                cmd.sum_clr = !sts.below_thr;
                state_next  = sts.below_thr ? S_IDLE : S_SUM_RD;
            end
            S_SUM_RD:
            begin
                cmd.rd_sel = RD_SUM;
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                cmd.sum_acc = 1'b1;
                state_next  = sts.sum_last ? S_DIV_C : S_SUM_RD;
            end
            S_DIV_C:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_CW;
            end
            S_DIV_CW:
            begin
                cmd.div_take = sts.div_done;
                if (sts.div_done)
                    state_next = S_DIV_S;
            end
            S_DIV_S:
            begin
                cmd.div_sel   = DIV_STS;
                cmd.div_start = 1'b1;
                state_next    = S_DIV_SW;
            end
            S_DIV_SW:
            begin
                cmd.div_sel  = DIV_STS;
                cmd.div_take = sts.div_done;
                if (sts.div_done)
                    state_next = S_CLASS;
            end
            S_CLASS:
            begin
                cmd.classify = 1'b1;
                state_next   = sts.need_div ? S_DIV_E : S_FIN;
            end
            S_DIV_E:
            begin
                cmd.div_sel   = DIV_ERR;
                cmd.div_start = 1'b1;
                state_next    = S_DIV_EW;
            end
            S_DIV_EW:
            begin
                cmd.div_sel  = DIV_ERR;
                cmd.div_take = sts.div_done;
                if (sts.div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = !sts.out_full;
                if (!sts.out_full)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ===== rtl/core/thruster_tracking_monitor_core.sv =====
// Top level of the thruster tracking monitor: controller plus datapath.
`timescale 1ns / 1ps

// Thruster tracking monitor. Each input transfer carries one thruster's new
// command and/or measured speed sample; the block keeps a 64-entry timed ring
// of each per thruster (two 512 x 64 memories, each with a write port and a
// read port, contents undefined until written, no clearing pass), evicts
// entries older than window_us, averages both rings and grades the relative
// tracking error against the tolerance. At most one result transfer leaves
// per input transfer. Items are handled one at a time: an item goes through
// bookkeeping, a read and a check per evicted entry, a read and an add per
// entry of the fuller ring for the sums (each ring memory gives one
// registered read per entry), and two or three divisions on the shared
// one-bit-per-cycle divider. Items that return no result end early. A
// finished result sits in an output register, so the next input is taken
// while it waits; only a second result stalls behind it. Configuration
// writes (cfg_ready is always high) must be made while the block is idle.

module thruster_tracking_monitor_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ttm_pkg::THR_W-1:0]          thruster,
    input  logic                               new_status,
    input  logic signed [ttm_pkg::SPD_W-1:0]   status_speed,
    input  logic [ttm_pkg::TIME_W-1:0]         status_time_us,
    input  logic                               new_command,
    input  logic signed [ttm_pkg::SPD_W-1:0]   command_speed,
    input  logic [ttm_pkg::TIME_W-1:0]         command_time_us,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ttm_pkg::THR_W-1:0]          thruster_out,
    output logic                               error_valid,
    output logic [31:0]                        tracking_error,
    output logic signed [ttm_pkg::SPD_W-1:0]   command_average,
    output logic signed [ttm_pkg::SPD_W-1:0]   status_average,
    output logic [ttm_pkg::FILL_W-1:0]         command_count,
    output logic [ttm_pkg::FILL_W-1:0]         status_count,
    output logic [ttm_pkg::TIME_W-1:0]         elapsed_us,
    output logic [ttm_pkg::TIME_W-1:0]         current_time_us,
    output logic                               underperforming,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ttm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ttm_pkg::CFG_W-1:0]          cfg_data
);
    import ttm_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // configuration transfers complete at once
    assign cfg_ready = 1'b1;

    ttm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ttm_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .thruster        (thruster),
        .new_status      (new_status),
        .status_speed    (status_speed),
        .status_time_us  (status_time_us),
        .new_command     (new_command),
        .command_speed   (command_speed),
        .command_time_us (command_time_us),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .thruster_out    (thruster_out),
        .error_valid     (error_valid),
        .tracking_error  (tracking_error),
        .command_average (command_average),
        .status_average  (status_average),
        .command_count   (command_count),
        .status_count    (status_count),
        .elapsed_us      (elapsed_us),
        .current_time_us (current_time_us),
        .underperforming (underperforming),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the thruster tracking monitor core.
`timescale 1ns / 1ps

module tb_top;
    import ttm_pkg::*;

    typedef struct {
        logic [THR_W-1:0]        thr;
        logic                    ns;
        logic signed [SPD_W-1:0] ss;
        logic [TIME_W-1:0]       st;
        logic                    nc;
        logic signed [SPD_W-1:0] cs;
        logic [TIME_W-1:0]       ct;
    } sample_t;

    typedef struct {
        logic [THR_W-1:0]        thr;
        logic                    ev;
        logic [31:0]             err;
        logic signed [SPD_W-1:0] cavg;
        logic signed [SPD_W-1:0] savg;
        logic [FILL_W-1:0]       ccnt;
        logic [FILL_W-1:0]       scnt;
        logic [TIME_W-1:0]       elapsed;
        logic [TIME_W-1:0]       cur;
        logic                    under;
    } report_t;

    localparam int CMD_RING = 0;
    localparam int STS_RING = 1;
    localparam int IDLE_PCT = 13;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE_CYCLES = 600;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [THR_W-1:0] thruster;
    logic new_status;
    logic signed [SPD_W-1:0] status_speed;
    logic [TIME_W-1:0] status_time_us;
    logic new_command;
    logic signed [SPD_W-1:0] command_speed;
    logic [TIME_W-1:0] command_time_us;
    logic out_valid;
    logic out_ready;
    logic [THR_W-1:0] thruster_out;
    logic error_valid;
    logic [31:0] tracking_error;
    logic signed [SPD_W-1:0] command_average;
    logic signed [SPD_W-1:0] status_average;
    logic [FILL_W-1:0] command_count;
    logic [FILL_W-1:0] status_count;
    logic [TIME_W-1:0] elapsed_us;
    logic [TIME_W-1:0] current_time_us;
    logic underperforming;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    thruster_tracking_monitor_core DUT (.*);

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Shadow configuration, updated on each config transfer
    int unsigned dead_zone_q;
    int unsigned tolerance_q;
    int unsigned window_q;
    int unsigned filter_q;
    int unsigned timeout_q;
    int unsigned min_samples_q;

    // Shadow per-thruster state: [ring][thruster][entry]
    logic [ENT_W-1:0] ring_ent [2][NUM_THR][DEPTH];
    int ring_head [2][NUM_THR];
    int ring_fill [2][NUM_THR];
    longint unsigned normal_since_q [NUM_THR];
    int last_cmd_speed [NUM_THR];
    longint unsigned last_cmd_time [NUM_THR];
    bit cmd_waiting [NUM_THR];

    sample_t pending_samples[$];
    report_t expected_reports[$];
    sample_t on_bus;
    int errors = 0;
    int n_in = 0;
    int watchdog = 0;

    // Stimulus generator state
    longint unsigned gen_time [NUM_THR];
    int gen_target [NUM_THR];

    task automatic ring_push(int r, int t, int spd, longint unsigned tm);
        logic [15:0] s16;
        logic [47:0] t48;
        s16 = spd[15:0];
        t48 = tm[47:0];
        ring_ent[r][t][ring_head[r][t]] = {s16, t48};
        ring_head[r][t] = (ring_head[r][t] + 1) % DEPTH;
        if (ring_fill[r][t] < DEPTH)
            ring_fill[r][t]++;
    endtask

    function automatic longint unsigned newest_time(int r, int t);
        return {16'b0, ring_ent[r][t][(ring_head[r][t] + DEPTH - 1) % DEPTH][47:0]};
    endfunction

    function automatic int newest_speed(int r, int t);
        logic [15:0] s16;
        s16 = ring_ent[r][t][(ring_head[r][t] + DEPTH - 1) % DEPTH][63:48];
        return int'($signed(s16));
    endfunction

    // Drop entries older than the window; signed age keeps future stamps
    task automatic ring_age_out(int r, int t, longint unsigned now);
        longint age;
        logic [47:0] ot;
        while (ring_fill[r][t] > 0)
        begin
            ot = ring_ent[r][t][(ring_head[r][t] + DEPTH - ring_fill[r][t]) % DEPTH][47:0];
            age = longint'(now) - longint'({16'b0, ot});
            if (age > longint'({32'b0, window_q}))
                ring_fill[r][t]--;
            else
                break;
        end
    endtask

    function automatic int ring_average(int r, int t);
        longint acc;
        logic [15:0] s16;
        acc = 0;
        for (int k = 0; k < ring_fill[r][t]; k++)
        begin
            s16 = ring_ent[r][t][(ring_head[r][t] + DEPTH - 1 - k) % DEPTH][63:48];
            acc += longint'($signed(s16));
        end
        return int'(acc / longint'(ring_fill[r][t]));
    endfunction

    // Track one accepted sample and queue the report it should produce
    task automatic track_sample(sample_t it);
        int t;
        int sp;
        int cavg;
        int savg;
        int ac;
        int as_mag;
        int dif;
        longint unsigned cmd_t;
        longint unsigned cur;
        longint unsigned err;
        longint unsigned elapsed;
        bit ev;
        bit under;
        bit stale;
        report_t rep;
        t = it.thr;
        err = 0;
        elapsed = 0;
        ev = 1'b1;
        under = 1'b0;
        if (it.nc)
        begin
            last_cmd_speed[t] = it.cs;
            last_cmd_time[t] = it.ct;
            cmd_waiting[t] = 1'b1;
        end
        if (it.ns)
        begin
            if (it.st == '0)
                return;
            ring_push(STS_RING, t, it.ss, it.st);
            if (cmd_waiting[t])
            begin
                ring_push(CMD_RING, t, last_cmd_speed[t], last_cmd_time[t]);
                cmd_waiting[t] = 1'b0;
            end
            else
            begin
                sp = 0;
                stale = (last_cmd_time[t] + longint'(timeout_q)) < {16'b0, it.st};
                if (ring_fill[CMD_RING][t] > 0 && !stale)
                    sp = newest_speed(CMD_RING, t);
                ring_push(CMD_RING, t, sp, it.st);
            end
        end
        if (ring_fill[CMD_RING][t] == 0 || ring_fill[STS_RING][t] == 0)
            return;
        cmd_t = newest_time(CMD_RING, t);
        cur = newest_time(STS_RING, t);
        if (cmd_t > cur)
            cur = cmd_t;
        if (normal_since_q[t] == 0)
        begin
            normal_since_q[t] = cur;
            return;
        end
        ring_age_out(CMD_RING, t, cur);
        ring_age_out(STS_RING, t, cur);
        if (ring_fill[CMD_RING][t] == 0 || ring_fill[STS_RING][t] == 0 ||
            ring_fill[CMD_RING][t] < min_samples_q || ring_fill[STS_RING][t] < min_samples_q)
            return;
        cavg = ring_average(CMD_RING, t);
        savg = ring_average(STS_RING, t);
        ac = cavg < 0 ? -cavg : cavg;
        as_mag = savg < 0 ? -savg : savg;
        if (ac <= int'(dead_zone_q) && as_mag <= int'(dead_zone_q))
        begin
            ev = 1'b0;
            normal_since_q[t] = cur;
        end
        else
        begin
            dif = cavg - savg;
            if (dif < 0)
                dif = -dif;
            if (ac == 0)
                err = 64'hFFFF_FFFF;
            else
            begin
                err = (longint'(dif) << 16) / longint'(ac);
                if (err > 64'hFFFF_FFFF)
                    err = 64'hFFFF_FFFF;
            end
            if (err <= longint'(tolerance_q))
                normal_since_q[t] = cur;
            else
            begin
                elapsed = cmd_t > normal_since_q[t] ? cmd_t - normal_since_q[t] : 0;
                under = elapsed > longint'(filter_q);
            end
        end
        rep.thr = t;
        rep.ev = ev;
        rep.err = err[31:0];
        rep.cavg = cavg[15:0];
        rep.savg = savg[15:0];
        rep.ccnt = ring_fill[CMD_RING][t];
        rep.scnt = ring_fill[STS_RING][t];
        rep.elapsed = elapsed[47:0];
        rep.cur = cur[47:0];
        rep.under = under;
        expected_reports.push_back(rep);
    endtask

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Random idling, off during a quiet stretch mid-run
    function automatic bit idle_now();
        if (n_in >= 260 && n_in < 330)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // Driver: one transfer slot, refilled from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            thruster <= '0;
            new_status <= 1'b0;
            status_speed <= '0;
            status_time_us <= '0;
            new_command <= 1'b0;
            command_speed <= '0;
            command_time_us <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                track_sample(on_bus);
                n_in <= n_in + 1;
            end
            if (pending_samples.size() > 0 && !idle_now())
            begin
                on_bus = pending_samples.pop_front();
                in_valid <= 1'b1;
                thruster <= on_bus.thr;
                new_status <= on_bus.ns;
                status_speed <= on_bus.ss;
                status_time_us <= on_bus.st;
                new_command <= on_bus.nc;
                command_speed <= on_bus.cs;
                command_time_us <= on_bus.ct;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: receiver stalls, including one long hold-off, and checks
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        report_t e;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transfer, expected none, actual thruster %0d",
                             $time, thruster_out);
                end
                else
                begin
                    e = expected_reports.pop_front();
                    check_field("thruster_out", e.thr, thruster_out);
                    check_field("error_valid", e.ev, error_valid);
                    check_field("tracking_error", e.err, tracking_error);
                    check_field("command_average", e.cavg, command_average);
                    check_field("status_average", e.savg, status_average);
                    check_field("command_count", e.ccnt, command_count);
                    check_field("status_count", e.scnt, status_count);
                    check_field("elapsed_us", e.elapsed, elapsed_us);
                    check_field("current_time_us", e.cur, current_time_us);
                    check_field("underperforming", e.under, underperforming);
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!hold_done && n_in >= 150)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !idle_now();
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DEAD_ZONE:  dead_zone_q = val[14:0];
            CFG_TOLERANCE:  tolerance_q = val[16:0];
            CFG_WINDOW:     window_q = val;
            CFG_ERR_FILTER: filter_q = val;
            CFG_CMD_TMO:    timeout_q = val;
            CFG_SAMP_THR:   min_samples_q = val[6:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int unsigned dz, int unsigned tol, int unsigned win,
                              int unsigned flt, int unsigned tmo, int unsigned thr);
        write_reg(CFG_DEAD_ZONE, dz);
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_ERR_FILTER, flt);
        write_reg(CFG_CMD_TMO, tmo);
        write_reg(CFG_SAMP_THR, thr);
    endtask

    task automatic add_sample(int t, bit ns, int ss, longint unsigned st,
                              bit nc, int cs, longint unsigned ct);
        sample_t s;
        s.thr = t;
        s.ns = ns;
        s.ss = ss[15:0];
        s.st = st[47:0];
        s.nc = nc;
        s.cs = cs[15:0];
        s.ct = ct[47:0];
        pending_samples.push_back(s);
    endtask

    // Mostly in-order samples that track a per-thruster target; some noise
    task automatic add_random(int thr_hi, int unsigned step_max);
        int t;
        int r;
        int ss;
        longint unsigned rt;
        t = $urandom_range(0, thr_hi);
        r = $urandom_range(0, 99);
        if (r < 88)
        begin
            gen_time[t] += $urandom_range(1, step_max);
            if ($urandom_range(0, 9) == 0)
                gen_target[t] = $signed($urandom_range(0, 65535) - 32768);
            if ($urandom_range(0, 3) == 0)
                ss = $signed($urandom_range(0, 65535) - 32768);
            else
                ss = gen_target[t] + $urandom_range(0, 400) - 200;
            add_sample(t, $urandom_range(0, 9) != 0, ss, gen_time[t],
                       $urandom_range(0, 9) < 6, gen_target[t],
                       gen_time[t] - $urandom_range(0, step_max / 2));
        end
        else
        begin
            rt = {$urandom, $urandom};
            add_sample(t, $urandom_range(0, 1), $urandom,
                       ($urandom_range(0, 2) == 0) ? 0 : rt,
                       $urandom_range(0, 1), $urandom, {$urandom, $urandom});
        end
    endtask

    // Wait until every result is in, then let trailing work finish
    task automatic drain();
        while (pending_samples.size() > 0 || in_valid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int k;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        dead_zone_q = 256;
        tolerance_q = 13107;
        window_q = 1000000;
        filter_q = 2000000;
        timeout_q = 1000000;
        min_samples_q = 4;
        for (int r = 0; r < 2; r++)
            for (int t = 0; t < NUM_THR; t++)
            begin
                ring_head[r][t] = 0;
                ring_fill[r][t] = 0;
            end
        for (int t = 0; t < NUM_THR; t++)
        begin
            normal_since_q[t] = 0;
            last_cmd_speed[t] = 0;
            last_cmd_time[t] = 0;
            cmd_waiting[t] = 1'b0;
            gen_time[t] = 1000;
            gen_target[t] = 1000 * (t + 1);
        end
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: normal, fault, idle, zero command, extreme speeds
        set_config(256, 13107, 100000, 200000, 50000, 4);
        for (k = 1; k <= 5; k++)
        begin
            add_sample(0, 1, 1000, k * 10000, 1, 1000, k * 10000);
            add_sample(1, 1, 0, k * 10000, 1, 2000, k * 10000);
            add_sample(2, 1, 0, k * 10000, 1, 0, k * 10000);
            add_sample(3, 1, 5000, k * 10000, (k == 1), 0, k * 10000);
        end
        add_sample(4, 1, 32767, 10, 1, -32768, 10);
        add_sample(4, 0, 0, 0, 1, 32767, 48'hFFFF_FFFF_FFFF);
        add_sample(4, 1, -32768, 0, 1, -32768, 20);
        add_sample(0, 0, 0, 0, 0, 0, 0);
        add_sample(5, 1, -1, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
        drain();

        for (k = 0; k < 100; k++)
            add_random(7, 20000);
        drain();

        set_config(0, 1, 32'hFFFF_FFFF, 0, 0, 1);
        for (k = 0; k < 80; k++)
            add_random(7, 50000);
        drain();

        set_config(32767, 65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64);
        for (k = 0; k < 80; k++)
            add_random(1, 1000);
        drain();

        set_config(512, 30000, 1, 1000, 5, 1);
        for (k = 0; k < 40; k++)
            add_random(7, 3);
        drain();

        set_config(128, 20000, 300000, 400000, 100000, 3);
        for (k = 0; k < 100; k++)
            add_random(7, 40000);
        drain();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
